/* rtl/tcc_pkg.sv */
// tcc_pkg: shared types, codes and default sizes of the text console cursor engine
// no dependencies

package tcc_pkg;

    // default screen geometry and command queue depth
    localparam int TCC_COLUMNS     = 80;
    localparam int TCC_ROWS        = 25;
    localparam int TCC_QUEUE_DEPTH = 4;

    // fixed widths of the cursor fields in a result
    localparam int TCC_ROW_FW = 5;
    localparam int TCC_COL_FW = 7;

    // item kinds
    localparam logic [1:0] KIND_PUT   = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // control characters
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    localparam logic [15:0] TCC_RESET_CELL  = 16'h0720;
    localparam logic [7:0]  TCC_COLOR_RESET = 8'd7;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } t_in_item;

    typedef struct packed {
        logic [15:0] cell_word;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
    } t_out_item;

    typedef enum logic [2:0] {
        OP_CHAR,
        OP_NEWLINE,
        OP_RETURN,
        OP_BACKSPACE,
        OP_TAB,
        OP_CLEAR,
        OP_READ,
        OP_NOP
    } t_op;

    // decoded command passed from the front end to the back end
    typedef struct packed {
        t_op        op;
        logic [7:0] ch;
        logic [4:0] read_row;
        logic [6:0] read_col;
        logic       in_range;
    } t_cmd;

endpackage

/* rtl/tcc_front.sv */
// tcc_front: accepts input items and decodes them into back end commands
// depends on tcc_pkg

module tcc_front import tcc_pkg::*; #(
    parameter int COLUMNS = TCC_COLUMNS,
    parameter int ROWS    = TCC_ROWS
) (
    input  logic     i_in_valid,
    input  t_in_item i_in_data,
    output logic     o_in_stall,
    input  logic     i_full,
    input  logic     i_busy,
    output logic     o_push,
    output t_cmd     o_cmd
);

    assign o_in_stall = i_full | i_busy;
    assign o_push     = i_in_valid & ~o_in_stall;

    always_comb begin
        o_cmd.ch       = i_in_data.char_code;
        o_cmd.read_row = i_in_data.read_row;
        o_cmd.read_col = i_in_data.read_col;
        o_cmd.in_range = (32'(i_in_data.read_row) < ROWS) &&
                         (32'(i_in_data.read_col) < COLUMNS);
        unique case (i_in_data.kind)
            KIND_PUT: begin
                unique case (i_in_data.char_code)
                    CH_NEWLINE:   o_cmd.op = OP_NEWLINE;
                    CH_RETURN:    o_cmd.op = OP_RETURN;
                    CH_BACKSPACE: o_cmd.op = OP_BACKSPACE;
                    CH_TAB:       o_cmd.op = OP_TAB;
                    default:      o_cmd.op = OP_CHAR;
                endcase
            end
            KIND_CLEAR: o_cmd.op = OP_CLEAR;
            KIND_READ:  o_cmd.op = OP_READ;
            default:    o_cmd.op = OP_NOP;
        endcase
    end

endmodule

/* rtl/tcc_queue.sv */
// tcc_queue: short command fifo between the front end and the back end
// depends on tcc_pkg

module tcc_queue import tcc_pkg::*; #(
    parameter int DEPTH = TCC_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [NW-1:0] r_count, n_count;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

/* rtl/tcc_back.sv */
// tcc_back: executes commands on the screen store and cursor, drives the result register
// depends on tcc_pkg

module tcc_back import tcc_pkg::*; #(
    parameter int COLUMNS = TCC_COLUMNS,
    parameter int ROWS    = TCC_ROWS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_text_color,
    input  logic       i_q_valid,
    input  t_cmd       i_q_cmd,
    output logic       o_pop,
    output logic       o_busy,
    output logic       o_out_valid,
    output t_out_item  o_out_data,
    input  logic       i_out_stall
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);

    typedef enum logic [5:0] {
        S_INIT   = 6'b000001,
        S_IDLE   = 6'b000010,
        S_READ   = 6'b000100,
        S_SCROLL = 6'b001000,
        S_CLEAR  = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

    t_state        r_state, n_state;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_top, n_top;
    logic [AW-1:0] r_sweep_addr, n_sweep_addr;
    logic [AW-1:0] r_sweep_last, n_sweep_last;
    logic [15:0]   r_fill_word, n_fill_word;
    logic [15:0]   r_word, n_word;
    logic          r_out_valid, n_out_valid;
    t_out_item     r_out_data, n_out_data;
    logic [15:0]   r_rd_data;
    logic [15:0]   r_mem [CELLS];

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic [AW-1:0] rd_addr;
    logic          do_nl;
    logic [CW:0]   col_step;

    // logical row to physical row of the ring of rows
    function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] lrow,
                                               input logic [RW-1:0] top);
        logic [RW:0] s;
        s = {1'b0, lrow} + {1'b0, top};
        if (s >= (RW+1)'(ROWS)) begin
            s = s - (RW+1)'(ROWS);
        end
        return s[RW-1:0];
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] prow,
                                                input logic [CW-1:0] col);
        return AW'(prow) * AW'(COLUMNS) + AW'(col);
    endfunction

    assign o_pop       = (r_state == S_IDLE) && i_q_valid;
    assign o_busy      = (r_state == S_INIT);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign rd_addr     = cell_addr(phys_row(RW'(i_q_cmd.read_row), r_top),
                                   CW'(i_q_cmd.read_col));

    always_comb begin
        n_state      = r_state;
        n_row        = r_row;
        n_col        = r_col;
        n_top        = r_top;
        n_sweep_addr = r_sweep_addr;
        n_sweep_last = r_sweep_last;
        n_fill_word  = r_fill_word;
        n_word       = r_word;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_data   = r_out_data;
        wr_en        = 1'b0;
        wr_addr      = r_sweep_addr;
        wr_data      = r_fill_word;
        do_nl        = 1'b0;
        col_step     = '0;

        unique case (r_state)
            S_INIT, S_SCROLL, S_CLEAR: begin
                wr_en = 1'b1;
                if (r_sweep_addr == r_sweep_last) begin
                    n_state = (r_state == S_INIT) ? S_IDLE : S_EMIT;
                end else begin
                    n_sweep_addr = r_sweep_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    n_word  = '0;
                    n_state = S_EMIT;
                    unique case (i_q_cmd.op)
                        OP_CHAR: begin
                            wr_en    = 1'b1;
                            wr_addr  = cell_addr(phys_row(r_row, r_top), r_col);
                            wr_data  = {i_text_color, i_q_cmd.ch};
                            col_step = {1'b0, r_col} + 1'b1;
                            if (col_step >= (CW+1)'(COLUMNS)) begin
                                do_nl = 1'b1;
                            end else begin
                                n_col = col_step[CW-1:0];
                            end
                        end
                        OP_NEWLINE: do_nl = 1'b1;
                        OP_RETURN:  n_col = '0;
                        OP_BACKSPACE: begin
                            if (r_col != '0) begin
                                n_col = r_col - 1'b1;
                            end
                        end
                        OP_TAB: begin
                            col_step = ({1'b0, r_col} + (CW+1)'(8)) & ~((CW+1)'(7));
                            if (col_step >= (CW+1)'(COLUMNS)) begin
                                do_nl = 1'b1;
                            end else begin
                                n_col = col_step[CW-1:0];
                            end
                        end
                        OP_CLEAR: begin
                            n_row        = '0;
                            n_col        = '0;
                            n_top        = '0;
                            n_sweep_addr = '0;
                            n_sweep_last = AW'(CELLS - 1);
                            n_fill_word  = {i_text_color, CH_SPACE};
                            n_state      = S_CLEAR;
                        end
                        OP_READ: begin
                            if (i_q_cmd.in_range) begin
                                n_state = S_READ;
                            end
                        end
                        default: ;
                    endcase

                    if (do_nl) begin
                        n_col = '0;
                        if (r_row == RW'(ROWS - 1)) begin
                            // scroll: the old top row becomes the new bottom row
                            n_top        = (r_top == RW'(ROWS - 1)) ? '0 : r_top + 1'b1;
                            n_sweep_addr = cell_addr(r_top, '0);
                            n_sweep_last = cell_addr(r_top, '0) + AW'(COLUMNS - 1);
                            n_fill_word  = {i_text_color, CH_SPACE};
                            n_state      = S_SCROLL;
                        end else begin
                            n_row = r_row + 1'b1;
                        end
                    end
                end
            end
            S_READ: begin
                n_word  = r_rd_data;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid           = 1'b1;
                    n_out_data.cell_word  = r_word;
                    n_out_data.cursor_row = TCC_ROW_FW'(r_row);
                    n_out_data.cursor_col = TCC_COL_FW'(r_col);
                    n_state               = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_row        <= '0;
            r_col        <= '0;
            r_top        <= '0;
            r_sweep_addr <= '0;
            r_sweep_last <= AW'(CELLS - 1);
            r_fill_word  <= TCC_RESET_CELL;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_row        <= n_row;
            r_col        <= n_col;
            r_top        <= n_top;
            r_sweep_addr <= n_sweep_addr;
            r_sweep_last <= n_sweep_last;
            r_fill_word  <= n_fill_word;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word     <= n_word;
        r_out_data <= n_out_data;
    end

    // screen store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

endmodule

/* rtl/text_console_cursor_engine_core.sv */
// Text console cursor engine, top level.
// Input channel (i_in_valid / o_in_stall / i_in_data) takes put, clear and read
// items; each item gives exactly one result on the output channel
// (o_out_valid / i_out_stall / o_out_data) with the cell read (0 unless a read)
// and the cursor position after the item. A transfer happens on a clock edge
// with valid high and stall low. The user must write the attribute register
// (i_cfg_valid / o_cfg_ready / i_cfg_data) only while no item is in flight;
// the block does not enforce it. Items are decoded into a small command queue,
// so the input keeps taking transfers while the back end works and while a
// result waits for the receiver. Back end steps per item: a plain character or
// cursor control goes from S_IDLE to S_EMIT, a read passes through S_READ, and
// when the cursor leaves the last row the bottom row is blanked one cell per
// cycle through the single store write port (S_SCROLL); a clear blanks every
// cell the same way (S_CLEAR). Scrolling rotates a row offset, so no cell is
// copied. After reset the store is filled with blank cells with o_in_stall
// high; configuration writes are taken.
// When the receiver stalls, the result holds in the output register and the
// back end waits; the input stalls once the command queue is full.
// depends on tcc_pkg, tcc_front, tcc_queue, tcc_back

module text_console_cursor_engine_core import tcc_pkg::*; #(
    parameter int COLUMNS     = TCC_COLUMNS,
    parameter int ROWS        = TCC_ROWS,
    parameter int QUEUE_DEPTH = TCC_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_in_item   i_in_data,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output t_out_item  o_out_data,
    input  logic       i_out_stall,
    input  logic       i_cfg_valid,
    input  logic [7:0] i_cfg_data,
    output logic       o_cfg_ready
);

    logic [7:0] r_text_color;
    logic       push;
    logic       full;
    logic       pop;
    logic       q_valid;
    logic       busy;
    t_cmd       front_cmd;
    t_cmd       q_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= TCC_COLOR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_text_color <= i_cfg_data;
        end
    end

    tcc_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_full     (full),
        .i_busy     (busy),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    tcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    tcc_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_text_color (r_text_color),
        .i_q_valid    (q_valid),
        .i_q_cmd      (q_cmd),
        .o_pop        (pop),
        .o_busy       (busy),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data),
        .i_out_stall  (i_out_stall)
    );

endmodule

/* rtl/tcc_checker.sv */
// tcc_checker: port level assertions for the text console cursor engine
// depends on tcc_pkg; bound to text_console_cursor_engine_core

module tcc_checker import tcc_pkg::*; #(
    parameter int COLUMNS = TCC_COLUMNS,
    parameter int ROWS    = TCC_ROWS
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input t_out_item o_out_data,
    input logic      i_out_stall
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // reset empties the result register and starts the fill with input stalled
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall && !o_out_valid)
        else $error("bad state after reset");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_out_data.cursor_col) < COLUMNS)
        else $error("cursor column past the right edge");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (ROWS <= 32) |-> 32'(o_out_data.cursor_row) < ROWS)
        else $error("cursor row past the last row");

endmodule

bind text_console_cursor_engine_core tcc_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);
